### rtl/lwbpc_pkg.sv
// Shared constants, request codes and store control type of the LRU write-back page cache.
package lwbpc_pkg;

  localparam int unsigned SlotsDef      = 16;
  localparam int unsigned FileIdBitsDef = 8;
  localparam int unsigned PageIdBitsDef = 20;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

### rtl/lwbpc_store.sv
// Slot store with one write port, one registered read port and per-entry reset values.
module lwbpc_store #(
  parameter int unsigned Depth     = 16,
  parameter int unsigned Width     = 8,
  parameter bit          IndexInit = 1'b0,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lwbpc_pkg::store_ctl_t ctl_i,
  input  logic [AddrBits-1:0]   rd_addr_i,
  input  logic [AddrBits-1:0]   wr_addr_i,
  input  logic [Width-1:0]      wr_data_i,
  output logic [Width-1:0]      rd_data_o
);

  logic [Width-1:0]    mem_q [Depth];
  logic [Depth-1:0]    vld_q;
  logic [Width-1:0]    rd_data_q;
  logic [AddrBits-1:0] rd_addr_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  // An entry that was never written reads as its reset value.
  assign rd_data_o = rd_vld_q ? rd_data_q : (IndexInit ? Width'(rd_addr_q) : '0);

endmodule

### rtl/lru_write_back_page_cache.sv
// Top level of the LRU write-back page cache tag and replacement engine.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   request | in_valid_i, in_ready_o, action_i,         | in
//           | file_id_i, page_id_i                      |
//   result  | out_valid_o, out_ready_i, slot_o, hit_o,  | out
//           | fill_o, writeback_o, wb_file_o, wb_page_o,|
//           | last_o                                    |
//
// A read or write request goes from acceptance to result through a scan of the tag and age
// stores for the hit or victim, a tag write, and a read-modify-write pass over the age store.
// A flush walks the slots in turn, reporting and clearing the dirty slots of its file.
// A request with file 0 or the unused action code gives only an empty final result.
// Reset leaves all slots empty and clean with ages equal to the slot numbers.
// A full result register stalls the engine until the result is taken.
module lru_write_back_page_cache #(
  parameter int unsigned SLOTS        = lwbpc_pkg::SlotsDef,
  parameter int unsigned FILE_ID_BITS = lwbpc_pkg::FileIdBitsDef,
  parameter int unsigned PAGE_ID_BITS = lwbpc_pkg::PageIdBitsDef,
  localparam int unsigned SlotBits    = $clog2(SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [FILE_ID_BITS-1:0] file_id_i,
  input  logic [PAGE_ID_BITS-1:0] page_id_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SlotBits-1:0]     slot_o,
  output logic                    hit_o,
  output logic                    fill_o,
  output logic                    writeback_o,
  output logic [FILE_ID_BITS-1:0] wb_file_o,
  output logic [PAGE_ID_BITS-1:0] wb_page_o,
  output logic                    last_o
);

  localparam int unsigned CntBits = SlotBits + 1;
  localparam int unsigned TagBits = FILE_ID_BITS + PAGE_ID_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LSCAN = 8'b0000_0010,
    S_LDEC  = 8'b0000_0100,
    S_ASCAN = 8'b0000_1000,
    S_RES   = 8'b0001_0000,
    S_FRD   = 8'b0010_0000,
    S_FEV   = 8'b0100_0000,
    S_MARK  = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  lwbpc_pkg::action_e      act_q, act_d;
  logic [FILE_ID_BITS-1:0] file_q, file_d;
  logic [PAGE_ID_BITS-1:0] page_q, page_d;
  logic                    found_q, found_d;
  logic [SlotBits-1:0]     hit_idx_q, hit_idx_d;
  logic [SlotBits-1:0]     hit_age_q, hit_age_d;
  logic                    hit_dirty_q, hit_dirty_d;
  logic [SlotBits-1:0]     vic_idx_q, vic_idx_d;
  logic [FILE_ID_BITS-1:0] vic_file_q, vic_file_d;
  logic [PAGE_ID_BITS-1:0] vic_page_q, vic_page_d;
  logic                    vic_dirty_q, vic_dirty_d;
  logic [SlotBits-1:0]     tgt_idx_q, tgt_idx_d;
  logic [SlotBits-1:0]     tgt_age_q, tgt_age_d;

  logic                    out_valid_q, out_valid_d;
  logic [SlotBits-1:0]     out_slot_q;
  logic                    out_hit_q, out_fill_q, out_wb_q, out_last_q;
  logic [FILE_ID_BITS-1:0] out_wbf_q;
  logic [PAGE_ID_BITS-1:0] out_wbp_q;

  lwbpc_pkg::store_ctl_t   tag_ctl, age_ctl;
  logic [SlotBits-1:0]     rd_addr;
  logic [SlotBits-1:0]     tag_wr_addr;
  logic [TagBits-1:0]      tag_wr_data, tag_rd;
  logic [SlotBits-1:0]     age_wr_data, age_rd;
  logic [FILE_ID_BITS-1:0] tag_file;
  logic [PAGE_ID_BITS-1:0] tag_page;
  logic                    tag_dirty;
  logic [CntBits-1:0]      cnt_m1;
  logic [SlotBits-1:0]     ev_idx;
  logic                    cnt_end, out_free, emit, load;

  logic [SlotBits-1:0]     e_slot;
  logic                    e_hit, e_fill, e_wb, e_last;
  logic [FILE_ID_BITS-1:0] e_wbf;
  logic [PAGE_ID_BITS-1:0] e_wbp;

  lwbpc_store #(
    .Depth    (SLOTS),
    .Width    (TagBits),
    .IndexInit(1'b0)
  ) u_tag_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tag_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(tag_wr_addr),
    .wr_data_i(tag_wr_data),
    .rd_data_o(tag_rd)
  );

  lwbpc_store #(
    .Depth    (SLOTS),
    .Width    (SlotBits),
    .IndexInit(1'b1)
  ) u_age_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (age_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(ev_idx),
    .wr_data_i(age_wr_data),
    .rd_data_o(age_rd)
  );

  assign tag_file  = tag_rd[TagBits-1 -: FILE_ID_BITS];
  assign tag_page  = tag_rd[PAGE_ID_BITS:1];
  assign tag_dirty = tag_rd[0];

  assign cnt_m1   = cnt_q - CntBits'(1);
  assign ev_idx   = cnt_m1[SlotBits-1:0];
  assign rd_addr  = cnt_q[SlotBits-1:0];
  assign cnt_end  = (cnt_q == CntBits'(SLOTS));
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = emit && out_free;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    file_d      = file_q;
    page_d      = page_q;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    hit_age_d   = hit_age_q;
    hit_dirty_d = hit_dirty_q;
    vic_idx_d   = vic_idx_q;
    vic_file_d  = vic_file_q;
    vic_page_d  = vic_page_q;
    vic_dirty_d = vic_dirty_q;
    tgt_idx_d   = tgt_idx_q;
    tgt_age_d   = tgt_age_q;
    tag_ctl     = '0;
    age_ctl     = '0;
    tag_wr_addr = rd_addr;
    tag_wr_data = '0;
    age_wr_data = '0;
    emit        = 1'b0;
    e_slot      = '0;
    e_hit       = 1'b0;
    e_fill      = 1'b0;
    e_wb        = 1'b0;
    e_wbf       = '0;
    e_wbp       = '0;
    e_last      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = lwbpc_pkg::action_e'(action_i);
          file_d  = file_id_i;
          page_d  = page_id_i;
          cnt_d   = '0;
          found_d = 1'b0;
          if (file_id_i == '0 || action_i == lwbpc_pkg::ACT_NONE) begin
            state_d = S_MARK;
          end else if (action_i == lwbpc_pkg::ACT_FLUSH) begin
            state_d = S_FRD;
          end else begin
            state_d = S_LSCAN;
          end
        end
      end
      S_LSCAN: begin
        if (!cnt_end) begin
          tag_ctl.rd_en = 1'b1;
          age_ctl.rd_en = 1'b1;
        end
        if (cnt_q != '0) begin
          if (!found_q && tag_file == file_q && tag_page == page_q) begin
            found_d     = 1'b1;
            hit_idx_d   = ev_idx;
            hit_age_d   = age_rd;
            hit_dirty_d = tag_dirty;
          end
          if (age_rd == SlotBits'(SLOTS - 1)) begin
            vic_idx_d   = ev_idx;
            vic_file_d  = tag_file;
            vic_page_d  = tag_page;
            vic_dirty_d = tag_dirty;
          end
        end
        if (cnt_end) begin
          state_d = S_LDEC;
        end else begin
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      S_LDEC: begin
        tag_ctl.wr_en = 1'b1;
        if (found_q) begin
          tag_wr_addr = hit_idx_q;
          tag_wr_data = {file_q, page_q, hit_dirty_q || act_q == lwbpc_pkg::ACT_WRITE};
          tgt_idx_d   = hit_idx_q;
          tgt_age_d   = hit_age_q;
        end else begin
          tag_wr_addr = vic_idx_q;
          tag_wr_data = {file_q, page_q, act_q == lwbpc_pkg::ACT_WRITE};
          tgt_idx_d   = vic_idx_q;
          tgt_age_d   = SlotBits'(SLOTS - 1);
        end
        cnt_d   = '0;
        state_d = S_ASCAN;
      end
      S_ASCAN: begin
        if (!cnt_end) begin
          age_ctl.rd_en = 1'b1;
        end
        if (cnt_q != '0) begin
          age_ctl.wr_en = 1'b1;
          if (ev_idx == tgt_idx_q) begin
            age_wr_data = '0;
          end else if (age_rd < tgt_age_q) begin
            age_wr_data = age_rd + SlotBits'(1);
          end else begin
            age_wr_data = age_rd;
          end
        end
        if (cnt_end) begin
          state_d = S_RES;
        end else begin
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      S_RES: begin
        emit   = 1'b1;
        e_slot = tgt_idx_q;
        e_hit  = found_q;
        e_fill = !found_q;
        e_last = 1'b1;
        if (!found_q && vic_file_q != '0 && vic_dirty_q) begin
          e_wb  = 1'b1;
          e_wbf = vic_file_q;
          e_wbp = vic_page_q;
        end
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MARK: begin
        emit   = 1'b1;
        e_last = 1'b1;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FRD: begin
        if (cnt_end) begin
          state_d = S_MARK;
        end else begin
          tag_ctl.rd_en = 1'b1;
          state_d       = S_FEV;
        end
      end
      S_FEV: begin
        if (tag_file == file_q && tag_dirty) begin
          emit   = 1'b1;
          e_slot = rd_addr;
          e_wb   = 1'b1;
          e_wbf  = tag_file;
          e_wbp  = tag_page;
          if (out_free) begin
            tag_ctl.wr_en = 1'b1;
            tag_wr_data   = '0;
            cnt_d         = cnt_q + CntBits'(1);
            state_d       = S_FRD;
          end
        end else begin
          cnt_d   = cnt_q + CntBits'(1);
          state_d = S_FRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    file_q      <= file_d;
    page_q      <= page_d;
    found_q     <= found_d;
    hit_idx_q   <= hit_idx_d;
    hit_age_q   <= hit_age_d;
    hit_dirty_q <= hit_dirty_d;
    vic_idx_q   <= vic_idx_d;
    vic_file_q  <= vic_file_d;
    vic_page_q  <= vic_page_d;
    vic_dirty_q <= vic_dirty_d;
    tgt_idx_q   <= tgt_idx_d;
    tgt_age_q   <= tgt_age_d;
    if (load) begin
      out_slot_q <= e_slot;
      out_hit_q  <= e_hit;
      out_fill_q <= e_fill;
      out_wb_q   <= e_wb;
      out_wbf_q  <= e_wbf;
      out_wbp_q  <= e_wbp;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = out_slot_q;
  assign hit_o       = out_hit_q;
  assign fill_o      = out_fill_q;
  assign writeback_o = out_wb_q;
  assign wb_file_o   = out_wbf_q;
  assign wb_page_o   = out_wbp_q;
  assign last_o      = out_last_q;

endmodule

### rtl/lwbpc_checker.sv
// Port-level checks of the LRU write-back page cache and their binding to the top level.
module lwbpc_checker #(
  parameter int unsigned SLOTS        = lwbpc_pkg::SlotsDef,
  parameter int unsigned FILE_ID_BITS = lwbpc_pkg::FileIdBitsDef,
  parameter int unsigned PAGE_ID_BITS = lwbpc_pkg::PageIdBitsDef,
  localparam int unsigned SlotBits    = $clog2(SLOTS)
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SlotBits-1:0]     slot_o,
  input logic                    hit_o,
  input logic                    fill_o,
  input logic                    writeback_o,
  input logic [FILE_ID_BITS-1:0] wb_file_o,
  input logic [PAGE_ID_BITS-1:0] wb_page_o,
  input logic                    last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o) && $stable(last_o)
      && $stable(wb_file_o) && $stable(wb_page_o))
    else $error("Result changed while stalled.");

  a_hit_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !fill_o && !writeback_o && last_o)
    else $error("A hit result carries a fill or write-back.");

  a_fill_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_o |-> last_o && !hit_o)
    else $error("A fill result is not the final result of its request.");

  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> writeback_o && !hit_o && !fill_o)
    else $error("A non-final result is not a flush write-back.");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A new request was taken right after another.");

endmodule

bind lru_write_back_page_cache lwbpc_checker #(
  .SLOTS       (SLOTS),
  .FILE_ID_BITS(FILE_ID_BITS),
  .PAGE_ID_BITS(PAGE_ID_BITS)
) u_lwbpc_checker (.*);

### tb/tb.sv
// Self-checking testbench for the LRU write-back page cache tag and replacement engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOTS = lwbpc_pkg::SlotsDef;
  localparam int unsigned FB = lwbpc_pkg::FileIdBitsDef;
  localparam int unsigned PB = lwbpc_pkg::PageIdBitsDef;
  localparam int unsigned SB = $clog2(NSLOTS);
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    lwbpc_pkg::action_e action;
    logic [FB-1:0]      file;
    logic [PB-1:0]      page;
  } page_req_t;

  typedef struct packed {
    logic [SB-1:0] slot;
    logic          hit;
    logic          fill;
    logic          writeback;
    logic [FB-1:0] wb_file;
    logic [PB-1:0] wb_page;
    logic          last;
  } cache_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_MOSTLY,
    RDY_PATTERN
  } stall_mode_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [1:0]    action_i = lwbpc_pkg::ACT_READ;
  logic [FB-1:0] file_id_i = '0;
  logic [PB-1:0] page_id_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [SB-1:0] slot_o;
  logic          hit_o;
  logic          fill_o;
  logic          writeback_o;
  logic [FB-1:0] wb_file_o;
  logic [PB-1:0] wb_page_o;
  logic          last_o;

  lru_write_back_page_cache uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .file_id_i   (file_id_i),
    .page_id_i   (page_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slot_o      (slot_o),
    .hit_o       (hit_o),
    .fill_o      (fill_o),
    .writeback_o (writeback_o),
    .wb_file_o   (wb_file_o),
    .wb_page_o   (wb_page_o),
    .last_o      (last_o)
  );

  page_req_t     request_q[$];
  cache_result_t expected_results[$];
  int            error_count = 0;
  int            idle_cycles = 0;

  logic [FB-1:0] tag_file[NSLOTS];
  logic [PB-1:0] tag_page[NSLOTS];
  logic          tag_dirty[NSLOTS];
  logic [SB-1:0] tag_age[NSLOTS];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void promote_slot(int s);
    logic [SB-1:0] a;
    a = tag_age[s];
    for (int i = 0; i < NSLOTS; i++) begin
      if (tag_age[i] < a) tag_age[i]++;
    end
    tag_age[s] = '0;
  endfunction

  function automatic void cache_lookup(lwbpc_pkg::action_e act, logic [FB-1:0] fid,
                                       logic [PB-1:0] pid);
    cache_result_t res;
    int victim;
    res = '0;
    res.last = 1'b1;
    if (fid == '0 || act == lwbpc_pkg::ACT_NONE) begin
      expected_results.push_back(res);
      return;
    end
    if (act == lwbpc_pkg::ACT_FLUSH) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (tag_file[i] == fid && tag_dirty[i]) begin
          res = '0;
          res.slot = SB'(i);
          res.writeback = 1'b1;
          res.wb_file = tag_file[i];
          res.wb_page = tag_page[i];
          expected_results.push_back(res);
          tag_file[i] = '0;
          tag_page[i] = '0;
          tag_dirty[i] = 1'b0;
        end
      end
      res = '0;
      res.last = 1'b1;
      expected_results.push_back(res);
      return;
    end
    for (int i = 0; i < NSLOTS; i++) begin
      if (tag_file[i] == fid && tag_page[i] == pid) begin
        promote_slot(i);
        if (act == lwbpc_pkg::ACT_WRITE) tag_dirty[i] = 1'b1;
        res.slot = SB'(i);
        res.hit = 1'b1;
        expected_results.push_back(res);
        return;
      end
    end
    victim = 0;
    for (int i = 1; i < NSLOTS; i++) begin
      if (tag_age[i] > tag_age[victim]) victim = i;
    end
    if (tag_file[victim] != '0 && tag_dirty[victim]) begin
      res.writeback = 1'b1;
      res.wb_file = tag_file[victim];
      res.wb_page = tag_page[victim];
    end
    tag_file[victim] = fid;
    tag_page[victim] = pid;
    tag_dirty[victim] = (act == lwbpc_pkg::ACT_WRITE);
    promote_slot(victim);
    res.slot = SB'(victim);
    res.fill = 1'b1;
    expected_results.push_back(res);
  endfunction

  function automatic void add_request(lwbpc_pkg::action_e act, logic [FB-1:0] fid,
                                      logic [PB-1:0] pid);
    page_req_t req;
    req.action = act;
    req.file = fid;
    req.page = pid;
    request_q.push_back(req);
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    page_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= lwbpc_pkg::ACT_READ;
      file_id_i <= '0;
      page_id_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
      for (int i = 0; i < NSLOTS; i++) begin
        tag_file[i] = '0;
        tag_page[i] = '0;
        tag_dirty[i] = 1'b0;
        tag_age[i] = SB'(i);
      end
    end else begin
      if (in_valid_i && in_ready_o) begin
        cache_lookup(lwbpc_pkg::action_e'(action_i), file_id_i, page_id_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= req.action;
          file_id_i <= req.file;
          page_id_i <= req.page;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 6) == 0) ? $urandom_range(10, 45)
                                                   : $urandom_range(0, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall behavior changes between several modes.
  stall_mode_e ready_mode;
  int          mode_left;
  logic [7:0]  ready_pat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_mode <= RDY_ALWAYS;
      mode_left <= 0;
      ready_pat <= 8'($urandom) | 8'h01;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      ready_pat <= {ready_pat[6:0], ready_pat[7]};
      case (ready_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_HALF: out_ready_i <= 1'($urandom_range(0, 1));
        RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ready_pat[0];
      endcase
    end
  end

  function automatic void compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0h last %0b",
                 $time, slot_o, last_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("slot", want.slot, slot_o);
        compare_field("hit", want.hit, hit_o);
        compare_field("fill", want.fill, fill_o);
        compare_field("writeback", want.writeback, writeback_o);
        compare_field("wb_file", want.wb_file, wb_file_o);
        compare_field("wb_page", want.wb_page, wb_page_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [FB-1:0]      file_pool[4];
    logic [PB-1:0]      page_pool[8];
    logic [FB-1:0]      fid;
    logic [PB-1:0]      pid;
    lwbpc_pkg::action_e act;
    int                 pick;

    add_request(lwbpc_pkg::ACT_READ, 8'h01, 20'h00000);
    add_request(lwbpc_pkg::ACT_WRITE, 8'h01, 20'h00000);
    add_request(lwbpc_pkg::ACT_WRITE, 8'hFF, 20'hFFFFF);
    add_request(lwbpc_pkg::ACT_READ, 8'hFF, 20'hFFFFF);
    add_request(lwbpc_pkg::ACT_READ, 8'h00, 20'h00005);
    add_request(lwbpc_pkg::ACT_NONE, 8'h01, 20'h00000);
    add_request(lwbpc_pkg::ACT_FLUSH, 8'h00, 20'h00000);
    add_request(lwbpc_pkg::ACT_FLUSH, 8'h02, 20'hFFFFF);
    add_request(lwbpc_pkg::ACT_WRITE, 8'h01, 20'hAAAAA);
    add_request(lwbpc_pkg::ACT_FLUSH, 8'h01, 20'h12345);
    for (int k = 0; k < 14; k++) begin
      add_request(lwbpc_pkg::ACT_WRITE, 8'h03, 20'h55555 + PB'(k));
    end
    add_request(lwbpc_pkg::ACT_FLUSH, 8'h03, 20'h00000);

    file_pool[0] = 8'h01;
    file_pool[1] = 8'h80;
    file_pool[2] = 8'($urandom_range(2, 254));
    file_pool[3] = 8'hFF;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int k = 2; k < 8; k++) page_pool[k] = PB'($urandom);

    for (int k = 0; k < 435; k++) begin
      fid = ($urandom_range(0, 3) != 0) ? file_pool[$urandom_range(0, 3)]
                                         : FB'($urandom_range(1, 255));
      pid = ($urandom_range(0, 3) != 0) ? page_pool[$urandom_range(0, 7)] : PB'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        act = lwbpc_pkg::action_e'($urandom_range(0, 3));
        fid = '0;
      end else if (pick < 8) begin
        act = lwbpc_pkg::ACT_NONE;
      end else if (pick < 20) begin
        act = lwbpc_pkg::ACT_FLUSH;
      end else if (pick < 60) begin
        act = lwbpc_pkg::ACT_READ;
      end else begin
        act = lwbpc_pkg::ACT_WRITE;
      end
      add_request(act, fid, pid);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (idle_cycles < IDLE_LIMIT &&
           (request_q.size() != 0 || in_valid_i || expected_results.size() != 0)) begin
      @(posedge clk_i);
    end
    if (idle_cycles < IDLE_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, expected_results.size());
      error_count++;
    end
    if (idle_cycles < IDLE_LIMIT && error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
